FILE: rtl/egcd_pkg.sv
// Shared types and constants for the extended GCD block.
`default_nettype none
package egcd_pkg;

  localparam int OP_W       = 31;               // operand and divisor width
  localparam int OUT_COEF_W = 32;               // coefficient width on the result item
  localparam int COEF_W_DEF = 32;               // default internal coefficient width
  localparam int IN_DATA_W  = 64;               // two operands padded to bytes
  localparam int OUT_DATA_W = 96;               // divisor and two coefficients padded
  localparam int DIV_CNT_W  = $clog2(OP_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(OP_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_UPD,
    S_FIN
  } egcd_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic publish;
  } egcd_cmd_t;

  typedef struct packed {
    logic b_zero;
  } egcd_sts_t;

endpackage
`default_nettype wire

FILE: rtl/egcd_dp.sv
// Datapath: operand registers, bit-serial divider and coefficient accumulators.
`default_nettype none
module egcd_dp #(
  parameter int WIDTH = egcd_pkg::COEF_W_DEF
) (
  input  wire logic                            clk,
  input  wire egcd_pkg::egcd_cmd_t             cmd,
  input  wire logic [egcd_pkg::OP_W-1:0]       in_a,
  input  wire logic [egcd_pkg::OP_W-1:0]       in_b,
  output egcd_pkg::egcd_sts_t                  sts,
  output logic [egcd_pkg::OP_W-1:0]            out_g,
  output logic [egcd_pkg::OUT_COEF_W-1:0]      out_x,
  output logic [egcd_pkg::OUT_COEF_W-1:0]      out_y
);
  import egcd_pkg::*;

  logic [OP_W-1:0]       a_r, a_nxt, b_r, b_nxt;
  logic [OP_W-1:0]       rem_r, rem_nxt, dvd_r, dvd_nxt;
  logic [WIDTH-1:0]      x_r, x_nxt, y_r, y_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic [WIDTH-1:0]      px_r, px_nxt, py_r, py_nxt;
  logic [OP_W-1:0]       g_r, g_nxt;
  logic [OUT_COEF_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;

  logic [OP_W:0]         shifted, diff;
  logic                  qbit;
  logic [WIDTH+OUT_COEF_W-1:0] x_ext, y_ext;

  // one restoring step: quotient bit and remainder
  assign shifted = {rem_r, dvd_r[OP_W-1]};
  assign diff    = shifted - {1'b0, b_r};
  assign qbit    = (shifted >= {1'b0, b_r});

  // sign-extend working coefficients into the result width
  assign x_ext = {{OUT_COEF_W{x_r[WIDTH-1]}}, x_r};
  assign y_ext = {{OUT_COEF_W{y_r[WIDTH-1]}}, y_r};

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    nx_nxt  = nx_r;
    ny_nxt  = ny_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    g_nxt   = g_r;
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    if (cmd.load) begin
      a_nxt  = in_a;
      b_nxt  = in_b;
      x_nxt  = WIDTH'(1);
      y_nxt  = '0;
      nx_nxt = '0;
      ny_nxt = WIDTH'(1);
    end
    if (cmd.div_init) begin
      rem_nxt = '0;
      dvd_nxt = a_r;
      px_nxt  = '0;
      py_nxt  = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = qbit ? diff[OP_W-1:0] : shifted[OP_W-1:0];
      dvd_nxt = {dvd_r[OP_W-2:0], 1'b0};
      // q*nx and q*ny built MSB first alongside the quotient, modulo 2^WIDTH
      px_nxt  = {px_r[WIDTH-2:0], 1'b0} + (qbit ? nx_r : '0);
      py_nxt  = {py_r[WIDTH-2:0], 1'b0} + (qbit ? ny_r : '0);
    end
    if (cmd.update) begin
      a_nxt  = b_r;
      b_nxt  = rem_r;
      x_nxt  = nx_r;
      nx_nxt = x_r - px_r;
      y_nxt  = ny_r;
      ny_nxt = y_r - py_r;
    end
    if (cmd.publish) begin
      g_nxt  = a_r;
      ox_nxt = x_ext[OUT_COEF_W-1:0];
      oy_nxt = y_ext[OUT_COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    g_r   <= g_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
  end

  assign sts.b_zero = (b_r == '0);
  assign out_g      = g_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;

endmodule
`default_nettype wire

FILE: rtl/egcd_ctrl.sv
// Controller: sequences load, divide rounds, updates and result hand-off.
`default_nettype none
module egcd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire egcd_pkg::egcd_sts_t  sts,
  output egcd_pkg::egcd_cmd_t       cmd
);
  import egcd_pkg::*;

  egcd_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_TEST;
      S_TEST: state_nxt = sts.b_zero ? S_FIN : S_DIV;
      S_DIV:  if (cnt_r == DIV_LAST) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_TEST;
      S_FIN:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_TEST: cmd.div_init = !sts.b_zero;
      S_DIV:  cmd.div_step = 1'b1;
      S_UPD:  cmd.update   = 1'b1;
      S_FIN:  cmd.publish  = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.div_init) begin
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/extended_gcd.sv
// Top level: extended Euclid block, greatest common divisor with Bezout coefficients.
//
// Usage: an input item carries operands a and b (31-bit unsigned); one result
// item follows with g = gcd(a, b) and coefficients x, y where a*x + b*y = g.
// Both channels use valid/ready handshakes; one item is in work at a time.
// Each Euclid round is one zero test, one step of the bit-serial restoring
// divider per operand bit, and one coefficient update; R, the number of
// rounds for an item, is at most 45 for 31-bit operands. The divider
// produces one quotient bit a cycle and builds q*nx and q*ny by
// shift-and-add in the same cycles, so no multiplier is used.
// The result sits in an output register: the next item is accepted as soon
// as that register has been loaded, even while the receiver stalls. A new
// result waits in the datapath until the register is free.
// Reset (synchronous, active low) empties the output register and returns
// the controller to idle. WIDTH sets the internal coefficient width; below
// 32 the coefficients wrap and are sign-extended on output.
`default_nettype none
module extended_gcd #(
  parameter int WIDTH = egcd_pkg::COEF_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [egcd_pkg::IN_DATA_W-1:0]    in_tdata,   // value_a, value_b, zero pad
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [egcd_pkg::OUT_DATA_W-1:0]        out_tdata   // divisor, coeff_a, coeff_b, pad
);
  import egcd_pkg::*;

  egcd_cmd_t             cmd;
  egcd_sts_t             sts;
  logic [OP_W-1:0]       g;
  logic [OUT_COEF_W-1:0] cx, cy;

  egcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  egcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .in_a  (in_tdata[OP_W-1:0]),
    .in_b  (in_tdata[2*OP_W-1:OP_W]),
    .sts   (sts),
    .out_g (g),
    .out_x (cx),
    .out_y (cy)
  );

  assign out_tdata = {{(OUT_DATA_W - OP_W - 2*OUT_COEF_W){1'b0}}, cy, cx, g};

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for extended_gcd: directed operand table, then random operand pairs.
module tb;
  import egcd_pkg::*;

  localparam int COEF_W     = COEF_W_DEF;
  localparam int IN_PAD_W   = IN_DATA_W - 2 * OP_W;
  localparam int RAND_ITEMS = 370;
  localparam int N_ROWS     = 18;
  localparam int DRAIN_CYC  = 1600;        // one worst-case item
  localparam int CYC_LIMIT  = 3_000_000;
  localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};

  typedef struct packed {
    logic [OP_W-1:0]       divisor;
    logic [OUT_COEF_W-1:0] coeff_a;
    logic [OUT_COEF_W-1:0] coeff_b;
  } gcd_result_t;

  typedef struct packed {
    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
    gcd_result_t     res;
  } gcd_job_t;

  typedef struct packed {
    logic [OP_W-1:0]     op_a;
    logic [OP_W-1:0]     op_b;
    logic [IN_PAD_W-1:0] pad;
    logic                fixed;        // res typed in below, else computed
    gcd_result_t         res;
  } gcd_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;     // value_a, value_b, zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;    // divisor, coeff_a, coeff_b, pad

  gcd_job_t    pending_gcds[$];
  gcd_job_t    rx_job;
  gcd_result_t rx_got;
  int          gcd_errors  = 0;
  int          cycle_count = 0;
  int          rx_hold     = 2;
  bit          rx_burst    = 1'b0;
  bit          tx_burst    = 1'b0;

  gcd_row_t directed_rows [N_ROWS] = '{
    '{31'd0,          31'd0,          2'b00, 1'b1, '{31'd0,      32'd1, 32'd0}},
    '{31'd5,          31'd0,          2'b00, 1'b1, '{31'd5,      32'd1, 32'd0}},
    '{31'd0,          31'd7,          2'b00, 1'b1, '{31'd7,      32'd0, 32'd1}},
    '{31'h7FFF_FFFF,  31'd0,          2'b00, 1'b1, '{31'h7FFF_FFFF, 32'd1, 32'd0}},
    '{31'd0,          31'h7FFF_FFFF,  2'b00, 1'b1, '{31'h7FFF_FFFF, 32'd0, 32'd1}},
    '{31'h7FFF_FFFF,  31'h7FFF_FFFF,  2'b00, 1'b1, '{31'h7FFF_FFFF, 32'd0, 32'd1}},
    '{31'd1,          31'd1,          2'b00, 1'b1, '{31'd1,      32'd0, 32'd1}},
    '{31'h7FFF_FFFF,  31'd1,          2'b00, 1'b1, '{31'd1,      32'd0, 32'd1}},
    '{31'd1,          31'd0,          2'b00, 1'b1, '{31'd1,      32'd1, 32'd0}},
    '{31'd1,          31'h7FFF_FFFF,  2'b00, 1'b0, '0},
    '{31'h7FFF_FFFF,  31'h7FFF_FFFE,  2'b00, 1'b0, '0},
    // two largest Fibonacci numbers below 2^31: the longest Euclid chain
    '{31'd1836311903, 31'd1134903170, 2'b00, 1'b0, '0},
    '{31'd1134903170, 31'd1836311903, 2'b00, 1'b0, '0},
    '{31'h5555_5555,  31'h2AAA_AAAA,  2'b00, 1'b0, '0},
    // pad bits set: must not leak into the operands
    '{31'd12,         31'd18,         2'b11, 1'b0, '0},
    '{31'h4000_0000,  31'h4000_0000,  2'b00, 1'b0, '0},
    '{31'h4000_0000,  31'd3,          2'b00, 1'b0, '0},
    '{31'd240,        31'd46,         2'b00, 1'b0, '0}
  };

  extended_gcd #(.WIDTH(COEF_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Euclid loop with coefficients held at COEF_W bits, widened to the result field
  function automatic gcd_result_t solve_bezout(logic [OP_W-1:0] op_a, logic [OP_W-1:0] op_b);
    logic [63:0] a, b, q, r, t, x, y, nx, ny, m;
    gcd_result_t res;
    m  = (64'd2 << (COEF_W - 1)) - 64'd1;
    a  = 64'(op_a);
    b  = 64'(op_b);
    x  = 64'd1;
    y  = 64'd0;
    nx = 64'd0;
    ny = 64'd1;
    while (b != 64'd0) begin
      q  = a / b;
      r  = a % b;
      a  = b;
      b  = r;
      t  = (x - q * nx) & m;
      x  = nx;
      nx = t;
      t  = (y - q * ny) & m;
      y  = ny;
      ny = t;
    end
    if (x[COEF_W-1]) x = x | ~m;
    if (y[COEF_W-1]) y = y | ~m;
    res.divisor = a[OP_W-1:0];
    res.coeff_a = x[OUT_COEF_W-1:0];
    res.coeff_b = y[OUT_COEF_W-1:0];
    return res;
  endfunction

  function automatic void pick_operands(output logic [OP_W-1:0] op_a,
                                        output logic [OP_W-1:0] op_b);
    logic [31:0] f0, f1, f2, g;
    logic [OP_W-1:0] tmp;
    case ($urandom_range(0, 9))
      4: begin
        op_a = OP_W'($urandom_range(0, 255));
        op_b = OP_W'($urandom_range(0, 255));
      end
      5: begin   // shared factor
        g    = $urandom_range(1, 65535);
        op_a = OP_W'(g * $urandom_range(0, OP_MAX / g));
        op_b = OP_W'(g * $urandom_range(0, OP_MAX / g));
      end
      6: begin   // one divides the other
        op_b = OP_W'($urandom_range(1, 65535));
        op_a = OP_W'(op_b * $urandom_range(0, 32767));
      end
      7: begin
        op_a = OP_W'($urandom);
        op_b = OP_W'($urandom_range(0, 1));
      end
      8: begin   // equal or adjacent
        op_a = OP_W'($urandom);
        op_b = op_a + OP_W'($urandom_range(0, 1));
      end
      9: begin   // consecutive terms of a Fibonacci-like run, many rounds
        f0 = $urandom_range(0, 3);
        f1 = $urandom_range(1, 3);
        while (f1 <= OP_MAX - f0) begin
          f2 = f0 + f1;
          f0 = f1;
          f1 = f2;
        end
        op_a = OP_W'(f1);
        op_b = OP_W'(f0);
      end
      default: begin
        op_a = OP_W'($urandom);
        op_b = OP_W'($urandom);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      tmp  = op_a;
      op_a = op_b;
      op_b = tmp;
    end
  endfunction

  // valid is only lowered when a gap follows, so it never toggles within one step
  task automatic send_pair(input logic [OP_W-1:0] op_a, input logic [OP_W-1:0] op_b,
                           input logic [IN_PAD_W-1:0] pad, input gcd_result_t want);
    int gap;
    gcd_job_t job;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pad, op_b, op_a};
    do @(posedge clk); while (!in_tready);
    job.op_a = op_a;
    job.op_b = op_b;
    job.res  = want;
    pending_gcds.insert(pending_gcds.size(), job);
  endtask

  initial begin
    logic [OP_W-1:0] op_a, op_b;
    gcd_result_t want;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].fixed ? directed_rows[i].res
                                    : solve_bezout(directed_rows[i].op_a, directed_rows[i].op_b);
      send_pair(directed_rows[i].op_a, directed_rows[i].op_b, directed_rows[i].pad, want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        // hold off until the block has drained completely
        in_tvalid <= 1'b0;
        while (pending_gcds.size() != 0) @(posedge clk);
      end
      pick_operands(op_a, op_b);
      send_pair(op_a, op_b, '0, solve_bezout(op_a, op_b));
    end

    in_tvalid <= 1'b0;
    while (pending_gcds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (gcd_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check each item, then draw the stall before the next one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_got.divisor = out_tdata[OP_W-1:0];
      rx_got.coeff_a = out_tdata[OP_W +: OUT_COEF_W];
      rx_got.coeff_b = out_tdata[OP_W + OUT_COEF_W +: OUT_COEF_W];
      if (pending_gcds.size() == 0) begin
        gcd_errors = gcd_errors + 1;
        if (gcd_errors <= 10)
          $display("unexpected result item: g=%0d x=%0d y=%0d", rx_got.divisor,
                   $signed(rx_got.coeff_a), $signed(rx_got.coeff_b));
      end else begin
        rx_job = pending_gcds.pop_front();
        if (rx_got.divisor !== rx_job.res.divisor || rx_got.coeff_a !== rx_job.res.coeff_a ||
            rx_got.coeff_b !== rx_job.res.coeff_b) begin
          gcd_errors = gcd_errors + 1;
          if (gcd_errors <= 10)
            $display("gcd(%0d, %0d): expected g=%0d x=%0d y=%0d, got g=%0d x=%0d y=%0d",
                     rx_job.op_a, rx_job.op_b, rx_job.res.divisor,
                     $signed(rx_job.res.coeff_a), $signed(rx_job.res.coeff_b),
                     rx_got.divisor, $signed(rx_got.coeff_a), $signed(rx_got.coeff_b));
        end
      end
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_hold = rx_burst ? 0 : $urandom_range(0, 3);
      out_tready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

FILE: extended_gcd.f
rtl/egcd_pkg.sv
rtl/egcd_dp.sv
rtl/egcd_ctrl.sv
rtl/extended_gcd.sv
bench/tb.sv
